FILE: sv/gbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the grid breadth-first path finder.
// No dependencies; every other file refers to this package by scoped names.
package gbp_pkg;

    localparam int COORD_W = 3;
    localparam int SIZE_W  = 4;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SIZE_W-1:0]  t_size;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_cell;

    typedef enum logic [2:0] {
        ST_STEP      = 3'd0,
        ST_BOUNDS    = 3'd1,
        ST_START_BLK = 3'd2,
        ST_GOAL_BLK  = 3'd3,
        ST_NO_PATH   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

    // register select is byte address bit 2
    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_CHK_S,
        S_CHK_G,
        S_INIT,
        S_POP,
        S_DEQ,
        S_NB,
        S_WALK,
        S_WALK_W,
        S_EMIT_RD,
        S_EMIT_WR,
        S_ERR
    } t_state;

    typedef struct packed {
        t_cell pos;
        t_dir  dir;
        logic  back;
    } t_step_req;

    typedef struct packed {
        t_cell pos;
        logic  ok;
    } t_step_rsp;

endpackage

`default_nettype wire

FILE: sv/gbp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for search requests and path results.
// Depends on gbp_pkg.
interface gbp_in_if;
    logic             valid;
    logic             ready;
    logic             action;
    gbp_pkg::t_coord  cell_row;
    gbp_pkg::t_coord  cell_col;
    logic             cell_blocked;
    gbp_pkg::t_coord  start_row;
    gbp_pkg::t_coord  start_col;
    gbp_pkg::t_coord  goal_row;
    gbp_pkg::t_coord  goal_col;

    modport source (output valid, action, cell_row, cell_col, cell_blocked,
                    start_row, start_col, goal_row, goal_col, input ready);
    modport sink   (input valid, action, cell_row, cell_col, cell_blocked,
                    start_row, start_col, goal_row, goal_col, output ready);
endinterface

interface gbp_out_if;
    logic             valid;
    logic             ready;
    gbp_pkg::t_status status;
    gbp_pkg::t_coord  step_row;
    gbp_pkg::t_coord  step_col;
    logic             last;

    modport source (output valid, status, step_row, step_col, last, input ready);
    modport sink   (input valid, status, step_row, step_col, last, output ready);
endinterface

`default_nettype wire

FILE: sv/gbp_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared neighbor step unit: moves one cell in a direction (or against it)
// and checks the result against the active grid size. Depends on gbp_pkg.
module gbp_step_unit (
    input  var gbp_pkg::t_step_req i_req,
    input  var gbp_pkg::t_size     i_rows,
    input  var gbp_pkg::t_size     i_cols,
    output var gbp_pkg::t_step_rsp o_rsp
);
    gbp_pkg::t_dir eff_dir;
    logic [gbp_pkg::SIZE_W-1:0] nb_row;
    logic [gbp_pkg::SIZE_W-1:0] nb_col;

    // walking back uses the opposite direction
    assign eff_dir = gbp_pkg::t_dir'(i_req.back ? (i_req.dir ^ 2'b10) : i_req.dir);

    always_comb begin
        nb_row = {1'b0, i_req.pos.row};
        nb_col = {1'b0, i_req.pos.col};
        case (eff_dir)
            gbp_pkg::DIR_UP:    nb_row = {1'b0, i_req.pos.row} - 4'd1;
            gbp_pkg::DIR_RIGHT: nb_col = {1'b0, i_req.pos.col} + 4'd1;
            gbp_pkg::DIR_DOWN:  nb_row = {1'b0, i_req.pos.row} + 4'd1;
            gbp_pkg::DIR_LEFT:  nb_col = {1'b0, i_req.pos.col} - 4'd1;
            default: ;
        endcase
    end

    // a step below zero wraps to 4'hF and fails the compare
    assign o_rsp.ok      = (nb_row < i_rows) && (nb_col < i_cols);
    assign o_rsp.pos.row = nb_row[gbp_pkg::COORD_W-1:0];
    assign o_rsp.pos.col = nb_col[gbp_pkg::COORD_W-1:0];

endmodule

`default_nettype wire

FILE: sv/grid_bfs_path_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// Grid breadth-first path finder. A load beat (action 0) writes one obstacle
// cell, gives no result and leaves the input ready. A search beat (action 1)
// checks the bounds, the start cell and the goal cell (states S_CHK, S_CHK_S,
// S_CHK_G) and clears the visited marks (S_INIT), then expands the frontier
// one cell at a time: S_POP and S_DEQ dequeue a cell, and S_NB tries its
// neighbors up, right, down, left through one shared step unit; the goal cell
// gets no neighbor step. The path is then walked back from goal, S_WALK and
// S_WALK_W for each cell (S_WALK alone for the start cell), and sent out start
// first, S_EMIT_RD and S_EMIT_WR for each beat. The input stays stalled from
// the accepting edge until a search has put its last beat into the output
// register, also while the receiver holds off. The queue, parent and path
// memories have registered reads, which splits dequeue, walk and emit into a
// read state and a use state. Errors give one beat with last set. Grid size
// registers sit at byte addresses 0 and 4.
// Depends on gbp_pkg, gbp_if and gbp_step_unit.
module grid_bfs_path_finder #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    gbp_in_if.sink          i_in,
    gbp_out_if.source       o_out,
    input  var logic        psel,
    input  var logic        penable,
    input  var logic        pwrite,
    input  var logic [2:0]  paddr,
    input  var logic [31:0] pwdata,
    output var logic [31:0] prdata,
    output var logic        pready
);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam logic [gbp_pkg::SIZE_W-1:0] ROWS_MAX = gbp_pkg::SIZE_W'(MAX_ROWS);
    localparam logic [gbp_pkg::SIZE_W-1:0] COLS_MAX = gbp_pkg::SIZE_W'(MAX_COLS);

    function automatic logic [CELL_W-1:0] cell_idx(input gbp_pkg::t_cell c);
        return CELL_W'(int'(c.row) * MAX_COLS + int'(c.col));
    endfunction

    gbp_pkg::t_state  r_state, n_state;
    gbp_pkg::t_size   r_rows, r_cols;
    gbp_pkg::t_size   rows_sat, cols_sat;
    logic [CELLS-1:0] r_obst;
    logic [CELLS-1:0] r_visited;
    gbp_pkg::t_cell   r_start, r_goal, r_cur;
    gbp_pkg::t_dir    r_dir;
    logic [CNT_W-1:0] r_head, r_tail, r_n;
    gbp_pkg::t_status r_err;

    gbp_pkg::t_cell   queue_mem [CELLS];
    gbp_pkg::t_dir    parent_mem [CELLS];
    gbp_pkg::t_cell   stack_mem [CELLS];
    gbp_pkg::t_cell   r_qdata, r_sdata;
    gbp_pkg::t_dir    r_pdata;

    logic             r_ovalid, r_olast;
    gbp_pkg::t_status r_ostatus;
    gbp_pkg::t_coord  r_orow, r_ocol;

    gbp_pkg::t_step_req step_req;
    gbp_pkg::t_step_rsp step_rsp;
    logic [CELL_W-1:0]  nb_idx, obst_addr, emit_addr;
    logic               obst_bit, nb_take, out_free, in_fire, bounds_ok, walk_more;

    // configuration
    assign pready = 1'b1;
    assign prdata = (gbp_pkg::t_reg'(paddr[2]) == gbp_pkg::REG_COLS) ?
                    {28'd0, r_cols} : {28'd0, r_rows};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd8;
            r_cols <= 4'd8;
        end else if (psel && penable && pwrite) begin
            if (gbp_pkg::t_reg'(paddr[2]) == gbp_pkg::REG_COLS) begin
                r_cols <= pwdata[3:0];
            end else begin
                r_rows <= pwdata[3:0];
            end
        end
    end

    assign rows_sat = (r_rows > ROWS_MAX) ? ROWS_MAX : r_rows;
    assign cols_sat = (r_cols > COLS_MAX) ? COLS_MAX : r_cols;

    // shared step unit
    always_comb begin
        step_req.pos  = r_cur;
        step_req.dir  = r_dir;
        step_req.back = 1'b0;
        if (r_state == gbp_pkg::S_WALK_W) begin
            step_req.dir  = r_pdata;
            step_req.back = 1'b1;
        end
    end

    gbp_step_unit u_step (
        .i_req  (step_req),
        .i_rows (rows_sat),
        .i_cols (cols_sat),
        .o_rsp  (step_rsp)
    );

    assign nb_idx = cell_idx(step_rsp.pos);

    always_comb begin
        case (r_state)
            gbp_pkg::S_CHK_S: obst_addr = cell_idx(r_start);
            gbp_pkg::S_CHK_G: obst_addr = cell_idx(r_goal);
            default:          obst_addr = nb_idx;
        endcase
    end
    assign obst_bit = r_obst[obst_addr];

    assign nb_take = (r_state == gbp_pkg::S_NB) && step_rsp.ok &&
                     !r_visited[nb_idx] && !obst_bit;
    assign bounds_ok = ({1'b0, r_start.row} < rows_sat) && ({1'b0, r_start.col} < cols_sat) &&
                       ({1'b0, r_goal.row} < rows_sat) && ({1'b0, r_goal.col} < cols_sat);
    assign walk_more = (r_cur != r_start) && (r_n < CNT_W'(CELLS - 1));
    assign out_free  = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == gbp_pkg::S_IDLE);
    assign in_fire   = i_in.valid && i_in.ready;
    assign emit_addr = r_n[CELL_W-1:0] - CELL_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbp_pkg::S_IDLE: begin
                if (in_fire && gbp_pkg::t_action'(i_in.action) == gbp_pkg::ACT_SEARCH) begin
                    n_state = gbp_pkg::S_CHK;
                end
            end
            gbp_pkg::S_CHK:    n_state = bounds_ok ? gbp_pkg::S_CHK_S : gbp_pkg::S_ERR;
            gbp_pkg::S_CHK_S:  n_state = obst_bit ? gbp_pkg::S_ERR : gbp_pkg::S_CHK_G;
            gbp_pkg::S_CHK_G:  n_state = obst_bit ? gbp_pkg::S_ERR : gbp_pkg::S_INIT;
            gbp_pkg::S_INIT:   n_state = gbp_pkg::S_POP;
            gbp_pkg::S_POP:    n_state = (r_head == r_tail) ? gbp_pkg::S_ERR : gbp_pkg::S_DEQ;
            gbp_pkg::S_DEQ:    n_state = (r_qdata == r_goal) ? gbp_pkg::S_WALK : gbp_pkg::S_NB;
            gbp_pkg::S_NB: begin
                if (r_dir == gbp_pkg::DIR_LEFT) begin
                    n_state = gbp_pkg::S_POP;
                end
            end
            gbp_pkg::S_WALK:   n_state = walk_more ? gbp_pkg::S_WALK_W : gbp_pkg::S_EMIT_RD;
            gbp_pkg::S_WALK_W: n_state = gbp_pkg::S_WALK;
            gbp_pkg::S_EMIT_RD: n_state = gbp_pkg::S_EMIT_WR;
            gbp_pkg::S_EMIT_WR: begin
                if (out_free) begin
                    n_state = (r_n == CNT_W'(1)) ? gbp_pkg::S_IDLE : gbp_pkg::S_EMIT_RD;
                end
            end
            gbp_pkg::S_ERR: begin
                if (out_free) begin
                    n_state = gbp_pkg::S_IDLE;
                end
            end
            default: n_state = gbp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // obstacle map and visited marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obst <= '0;
        end else if (in_fire && gbp_pkg::t_action'(i_in.action) == gbp_pkg::ACT_LOAD &&
                     int'(i_in.cell_row) < MAX_ROWS && int'(i_in.cell_col) < MAX_COLS) begin
            r_obst[cell_idx({i_in.cell_row, i_in.cell_col})] <= i_in.cell_blocked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gbp_pkg::S_INIT) begin
            // clear all marks and set the start cell in one write
            r_visited <= {{(CELLS-1){1'b0}}, 1'b1} << cell_idx(r_start);
        end else if (nb_take) begin
            r_visited[nb_idx] <= 1'b1;
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_n    <= '0;
        end else begin
            case (r_state)
                gbp_pkg::S_IDLE: begin
                    if (in_fire) begin
                        r_start <= {i_in.start_row, i_in.start_col};
                        r_goal  <= {i_in.goal_row, i_in.goal_col};
                    end
                end
                gbp_pkg::S_CHK:   r_err <= gbp_pkg::ST_BOUNDS;
                gbp_pkg::S_CHK_S: r_err <= gbp_pkg::ST_START_BLK;
                gbp_pkg::S_CHK_G: r_err <= gbp_pkg::ST_GOAL_BLK;
                gbp_pkg::S_INIT: begin
                    r_head <= '0;
                    r_tail <= CNT_W'(1);
                    r_err  <= gbp_pkg::ST_NO_PATH;
                end
                gbp_pkg::S_DEQ: begin
                    r_head <= r_head + CNT_W'(1);
                    r_cur  <= r_qdata;
                    r_dir  <= gbp_pkg::DIR_UP;
                    r_n    <= '0;
                end
                gbp_pkg::S_NB: begin
                    r_dir <= gbp_pkg::t_dir'(r_dir + 2'd1);
                    if (nb_take) begin
                        r_tail <= r_tail + CNT_W'(1);
                    end
                end
                gbp_pkg::S_WALK:   r_n <= r_n + CNT_W'(1);
                gbp_pkg::S_WALK_W: r_cur <= step_rsp.pos;
                gbp_pkg::S_EMIT_WR: begin
                    if (out_free) begin
                        r_n <= r_n - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // memories: queue, parent directions, path stack
    always_ff @(posedge i_clk) begin
        if (r_state == gbp_pkg::S_INIT) begin
            queue_mem[0] <= r_start;
        end else if (nb_take) begin
            queue_mem[r_tail[CELL_W-1:0]] <= step_rsp.pos;
        end
        r_qdata <= queue_mem[r_head[CELL_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (nb_take) begin
            parent_mem[nb_idx] <= r_dir;
        end
        r_pdata <= parent_mem[cell_idx(r_cur)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gbp_pkg::S_WALK) begin
            stack_mem[r_n[CELL_W-1:0]] <= r_cur;
        end
        r_sdata <= stack_mem[emit_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == gbp_pkg::S_EMIT_WR && out_free) begin
            r_ovalid  <= 1'b1;
            r_ostatus <= gbp_pkg::ST_STEP;
            r_orow    <= r_sdata.row;
            r_ocol    <= r_sdata.col;
            r_olast   <= (r_n == CNT_W'(1));
        end else if (r_state == gbp_pkg::S_ERR && out_free) begin
            r_ovalid  <= 1'b1;
            r_ostatus <= r_err;
            r_orow    <= '0;
            r_ocol    <= '0;
            r_olast   <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.status   = r_ostatus;
    assign o_out.step_row = r_orow;
    assign o_out.step_col = r_ocol;
    assign o_out.last     = r_olast;

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != gbp_pkg::ST_STEP |->
            o_out.last && o_out.step_row == '0 && o_out.step_col == '0)
        else $error("error beat not final or not zeroed");

    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && gbp_pkg::t_action'(i_in.action) == gbp_pkg::ACT_LOAD |=> i_in.ready)
        else $error("load beat stalled the input");

    a_start_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gbp_pkg::S_POP |-> r_visited[cell_idx(r_start)])
        else $error("start cell not marked visited");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CNT_W'(CELLS))
        else $error("queue tail beyond capacity");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for grid_bfs_path_finder: loads obstacle grids, runs searches and
// checks every path or error beat against a breadth-first predictor.
// Depends on gbp_pkg and gbp_if from the RTL.
module tb;

    typedef struct {
        gbp_pkg::t_action action;
        gbp_pkg::t_coord  cell_row;
        gbp_pkg::t_coord  cell_col;
        logic             cell_blocked;
        gbp_pkg::t_coord  start_row;
        gbp_pkg::t_coord  start_col;
        gbp_pkg::t_coord  goal_row;
        gbp_pkg::t_coord  goal_col;
    } t_job;

    typedef struct {
        gbp_pkg::t_status status;
        gbp_pkg::t_coord  row;
        gbp_pkg::t_coord  col;
        logic             last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gbp_in_if  in_ch ();
    gbp_out_if out_ch ();

    grid_bfs_path_finder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] blocked_map;
    logic [3:0]  size_rows;
    logic [3:0]  size_cols;
    t_beat       path_q[$];

    int  mismatches = 0;
    bit  failed = 1'b0;
    int  out_hold = 0;      // long receiver hold-off, in cycles
    bit  out_calm = 1'b0;   // no receiver stalls while set
    bit  in_calm = 1'b0;    // no sender gaps while set

    function automatic void add_beat(t_beat b);
        path_q.insert(path_q.size(), b);
    endfunction

    function automatic void push_error(gbp_pkg::t_status code);
        t_beat b;
        b.status = code;
        b.row = '0;
        b.col = '0;
        b.last = 1'b1;
        add_beat(b);
    endfunction

    function automatic void predict_path(t_job j);
        int rows, cols, s, g, head, tail, cur, at, n, d, nr, nc, ni;
        int dr[4], dc[4];
        bit seen[64];
        int dir_of[64];
        int fifo[64];
        int trail[64];
        bit found;
        t_beat b;
        dr = '{-1, 0, 1, 0};
        dc = '{0, 1, 0, -1};
        if (j.action == gbp_pkg::ACT_LOAD) begin
            blocked_map[j.cell_row * 8 + j.cell_col] = j.cell_blocked;
            return;
        end
        rows = (size_rows > 8) ? 8 : size_rows;
        cols = (size_cols > 8) ? 8 : size_cols;
        if (j.start_row >= rows || j.start_col >= cols ||
            j.goal_row >= rows || j.goal_col >= cols) begin
            push_error(gbp_pkg::ST_BOUNDS);
            return;
        end
        s = j.start_row * 8 + j.start_col;
        g = j.goal_row * 8 + j.goal_col;
        if (blocked_map[s]) begin
            push_error(gbp_pkg::ST_START_BLK);
            return;
        end
        if (blocked_map[g]) begin
            push_error(gbp_pkg::ST_GOAL_BLK);
            return;
        end
        foreach (seen[k]) seen[k] = 1'b0;
        head = 0;
        tail = 1;
        fifo[0] = s;
        seen[s] = 1'b1;
        found = 1'b0;
        while (head < tail) begin
            cur = fifo[head];
            head++;
            if (cur == g) begin
                found = 1'b1;
                break;
            end
            for (d = 0; d < 4; d++) begin
                nr = cur / 8 + dr[d];
                nc = cur % 8 + dc[d];
                if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
                ni = nr * 8 + nc;
                if (seen[ni] || blocked_map[ni]) continue;
                seen[ni] = 1'b1;
                dir_of[ni] = d;
                if (tail < 64) begin
                    fifo[tail] = ni;
                    tail++;
                end
            end
        end
        if (!found) begin
            push_error(gbp_pkg::ST_NO_PATH);
            return;
        end
        n = 0;
        at = g;
        while (at != s && n < 63) begin
            trail[n] = at;
            n++;
            at = (at / 8 - dr[dir_of[at]]) * 8 + (at % 8 - dc[dir_of[at]]);
        end
        trail[n] = s;
        n++;
        for (int k = 0; k < n; k++) begin
            b.status = gbp_pkg::ST_STEP;
            b.row = gbp_pkg::t_coord'(trail[n - 1 - k] / 8);
            b.col = gbp_pkg::t_coord'(trail[n - 1 - k] % 8);
            b.last = (k == n - 1);
            add_beat(b);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (path_q.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d row %0d col %0d last %0b",
                             out_ch.status, out_ch.step_row, out_ch.step_col, out_ch.last);
            end else begin
                e = path_q.pop_front();
                if (out_ch.status !== e.status || out_ch.step_row !== e.row ||
                    out_ch.step_col !== e.col || out_ch.last !== e.last) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 e.status, e.row, e.col, e.last, out_ch.status,
                                 out_ch.step_row, out_ch.step_col, out_ch.last);
                end
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // receiver stalls
    initial begin
        int gap_left;
        gap_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold > 0) begin
                out_ch.ready = 1'b0;
                out_hold--;
            end else if (gap_left > 0 && !out_calm) begin
                out_ch.ready = 1'b0;
                gap_left--;
            end else begin
                out_ch.ready = 1'b1;
                gap_left = out_calm ? 0 : pick_gap();
            end
        end
    end

    task automatic send_job(t_job j);
        int gap;
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.action = j.action;
        in_ch.cell_row = j.cell_row;
        in_ch.cell_col = j.cell_col;
        in_ch.cell_blocked = j.cell_blocked;
        in_ch.start_row = j.start_row;
        in_ch.start_col = j.start_col;
        in_ch.goal_row = j.goal_row;
        in_ch.goal_col = j.goal_col;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_path(j);
        gap = in_calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_job rand_job();
        t_job j;
        j.action = gbp_pkg::t_action'($urandom_range(0, 1));
        j.cell_row = gbp_pkg::t_coord'($urandom_range(0, 7));
        j.cell_col = gbp_pkg::t_coord'($urandom_range(0, 7));
        j.cell_blocked = 1'($urandom_range(0, 1));
        j.start_row = gbp_pkg::t_coord'($urandom_range(0, 7));
        j.start_col = gbp_pkg::t_coord'($urandom_range(0, 7));
        j.goal_row = gbp_pkg::t_coord'($urandom_range(0, 7));
        j.goal_col = gbp_pkg::t_coord'($urandom_range(0, 7));
        return j;
    endfunction

    task automatic load_cell(int r, int c, logic blk);
        t_job j;
        j = rand_job();
        j.action = gbp_pkg::ACT_LOAD;
        j.cell_row = gbp_pkg::t_coord'(r);
        j.cell_col = gbp_pkg::t_coord'(c);
        j.cell_blocked = blk;
        send_job(j);
    endtask

    task automatic search(int sr, int sc, int gr, int gc);
        t_job j;
        j = rand_job();
        j.action = gbp_pkg::ACT_SEARCH;
        j.start_row = gbp_pkg::t_coord'(sr);
        j.start_col = gbp_pkg::t_coord'(sc);
        j.goal_row = gbp_pkg::t_coord'(gr);
        j.goal_col = gbp_pkg::t_coord'(gc);
        send_job(j);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(gbp_pkg::t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {r, 2'b00};
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (r == gbp_pkg::REG_ROWS) size_rows = v[3:0];
        else size_cols = v[3:0];
    endtask

    task automatic set_size(int r, int c);
        wait_drained();
        apb_write(gbp_pkg::REG_ROWS, 32'(r));
        apb_write(gbp_pkg::REG_COLS, 32'(c));
    endtask

    task automatic test_directed();
        set_size(8, 8);
        search(0, 0, 7, 7);
        search(7, 7, 0, 0);
        search(3, 4, 3, 4);
        // wall across column 3 with a gap at the bottom
        for (int r = 0; r < 7; r++) load_cell(r, 3, 1'b1);
        search(0, 0, 0, 7);
        load_cell(7, 3, 1'b1);
        search(0, 0, 0, 7);
        search(0, 3, 0, 7);
        search(0, 0, 2, 3);
        search(0, 3, 9 % 8, 3);
        set_size(4, 15);
        load_cell(7, 7, 1'b1);
        search(5, 0, 0, 0);
        search(0, 0, 3, 7);
        set_size(8, 9);
        search(0, 0, 7, 7);
        search(7, 7, 7, 7);
        set_size(0, 8);
        search(0, 0, 0, 0);
        set_size(1, 1);
        search(0, 0, 0, 0);
        search(0, 1, 0, 0);
        set_size(8, 8);
        for (int r = 0; r < 8; r++) load_cell(r, 3, 1'b0);
        load_cell(7, 7, 1'b0);
    endtask

    task automatic test_random(int n_items);
        int sent, rr, cc, pct, start_idx, goal_idx;
        logic [63:0] m;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                send_job(rand_job());
                sent++;
                continue;
            end
            rr = (size_rows > 8) ? 8 : size_rows;
            cc = (size_cols > 8) ? 8 : size_cols;
            pct = $urandom_range(5, 35);
            repeat ($urandom_range(1, 8)) begin
                load_cell($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 99) < pct);
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                if (rr == 0 || cc == 0 || $urandom_range(0, 9) == 0) begin
                    search($urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom_range(0, 7));
                end else begin
                    m = blocked_map;
                    start_idx = $urandom_range(0, rr - 1) * 8 + $urandom_range(0, cc - 1);
                    goal_idx = $urandom_range(0, rr - 1) * 8 + $urandom_range(0, cc - 1);
                    // prefer free endpoints so most searches reach the walk
                    for (int t = 0; t < 6 && m[start_idx]; t++)
                        start_idx = $urandom_range(0, rr - 1) * 8 + $urandom_range(0, cc - 1);
                    for (int t = 0; t < 6 && m[goal_idx]; t++)
                        goal_idx = $urandom_range(0, rr - 1) * 8 + $urandom_range(0, cc - 1);
                    search(start_idx / 8, start_idx % 8, goal_idx / 8, goal_idx % 8);
                end
                sent++;
            end
        end
    endtask

    task automatic test_sizes();
        set_size(8, 8);
        test_random(90);
        set_size($urandom_range(2, 7), $urandom_range(2, 7));
        test_random(60);
        set_size(1, 8);
        test_random(25);
        set_size(8, 1);
        test_random(25);
        set_size(12, 8);
        out_calm = 1'b1;
        in_calm = 1'b1;
        test_random(40);
        out_calm = 1'b0;
        in_calm = 1'b0;
        set_size(8, 8);
    endtask

    task automatic test_backpressure();
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++) load_cell(r, c, 1'b0);
        out_hold = 800;
        repeat (8) search(0, 0, 7, 7);
        search(7, 0, 0, 7);
        wait_drained();
        test_random(30);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = gbp_pkg::ACT_LOAD;
        in_ch.cell_row = '0;
        in_ch.cell_col = '0;
        in_ch.cell_blocked = 1'b0;
        in_ch.start_row = '0;
        in_ch.start_col = '0;
        in_ch.goal_row = '0;
        in_ch.goal_col = '0;
        blocked_map = '0;
        size_rows = 4'd8;
        size_cols = 4'd8;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_sizes();
        test_backpressure();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (failed || path_q.size() != 0) begin
            $display("Verification failed");
        end else begin
            $display("Verification passed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end
endmodule

FILE: sim.f
sv/gbp_pkg.sv
sv/gbp_if.sv
sv/gbp_step_unit.sv
sv/grid_bfs_path_finder.sv
dv/tb.sv
